// ===== sv/salc_pkg.sv =====
`timescale 1ns / 1ps
package salc_pkg;

  localparam int TOTAL_LINES_DEF = 512;
  localparam int OFFSET_BITS_DEF = 5;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int COUNT_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE = 1'd1;

  localparam logic [CFG_DATA_W-1:0] WAYS_LOG2_RESET = 4'd1;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan;
    logic upd;
    logic rst_cnt;
    logic finish;
  } salc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_done;
    logic hit;
    logic alloc_ok;
    logic out_free;
  } salc_sts_t;

endpackage

// ===== sv/salc_if.sv =====
`timescale 1ns / 1ps
interface salc_req_if #(parameter int ADDR_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic                 is_load;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, is_load, address, input ready);
  modport sink (input valid, is_load, address, output ready);
endinterface

interface salc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        allocated;
  logic [31:0] hit_count;
  logic [31:0] access_count;
  modport source (output valid, hit, allocated, hit_count, access_count, input ready);
  modport sink (input valid, hit, allocated, hit_count, access_count, output ready);
endinterface

// ===== sv/salc_ctrl.sv =====
`timescale 1ns / 1ps
module salc_ctrl
  import salc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  salc_sts_t sts,
  output salc_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_UPD   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.walk_done) begin
          if (sts.hit || sts.alloc_ok) begin
            cmd.rst_cnt = 1'b1;
            state_next  = S_UPD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.walk_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== sv/salc_datapath.sv =====
`timescale 1ns / 1ps
module salc_datapath
  import salc_pkg::*;
#(
  parameter int TOTAL_LINES = TOTAL_LINES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  is_load,
  input  logic [ADDR_BITS-1:0]  address,
  input  salc_cmd_t             cmd,
  output salc_sts_t             sts,
  salc_rsp_if.source            rsp
);

  localparam int LINE_W = $clog2(TOTAL_LINES);
  localparam int TAG_W  = ADDR_BITS - OFFSET_BITS;
  localparam int WL_W   = $clog2(LINE_W + 1);

  typedef struct packed {
    logic              valid;
    logic [LINE_W-1:0] rec;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  entry_t mem [TOTAL_LINES];

  logic [CFG_DATA_W-1:0] ways_log2;
  logic                  write_allocate;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2      <= WAYS_LOG2_RESET;
      write_allocate <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAYS_LOG2:      ways_log2 <= cfg_data;
        REG_WRITE_ALLOCATE: write_allocate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // set and tag split of the incoming address
  logic [WL_W-1:0]   wl;
  logic [WL_W-1:0]   set_log;
  logic [TAG_W-1:0]  line;
  logic [LINE_W-1:0] set_mask;
  logic [LINE_W-1:0] base_in;
  logic [TAG_W-1:0]  tag_in;
  logic [LINE_W:0]   ways_in;

  always_comb begin
    wl       = (ways_log2 > CFG_DATA_W'(LINE_W)) ? WL_W'(LINE_W) : WL_W'(ways_log2);
    set_log  = WL_W'(LINE_W) - wl;
    line     = address[ADDR_BITS-1:OFFSET_BITS];
    set_mask = LINE_W'(({{LINE_W{1'b0}}, 1'b1} << set_log) - 1'b1);
    base_in  = (line[LINE_W-1:0] & set_mask) << wl;
    tag_in   = line >> set_log;
    ways_in  = {{LINE_W{1'b0}}, 1'b1} << wl;
  end

  logic [LINE_W-1:0] base_r;
  logic [TAG_W-1:0]  tag_r;
  logic [LINE_W:0]   ways_r;
  logic              load_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base_r <= base_in;
      tag_r  <= tag_in;
      ways_r <= ways_in;
      load_r <= is_load;
    end
  end

  logic [LINE_W-1:0] top;
  assign top = LINE_W'(ways_r - 1'b1);

  // way walk: read issued at rd_cnt, data evaluated in the next cycle at rd_way
  logic [LINE_W:0]   rd_cnt;
  logic              rd_on;
  logic              rd_vld;
  logic [LINE_W-1:0] rd_way;
  logic [LINE_W-1:0] clr_cnt;
  entry_t            q;

  assign rd_on = (cmd.scan || cmd.upd) && (rd_cnt < ways_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt  <= '0;
      rd_vld  <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cmd.start || cmd.rst_cnt) begin
        rd_cnt <= '0;
      end else if (rd_on) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      rd_vld <= rd_on;
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_way <= rd_cnt[LINE_W-1:0];
    q      <= mem[base_r | rd_cnt[LINE_W-1:0]];
  end

  // scan results
  logic              hit_f, inv_f;
  logic [LINE_W-1:0] hit_way, inv_way, min_way, min_rec, hit_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_f <= 1'b0;
      inv_f <= 1'b0;
    end else if (cmd.start) begin
      hit_f <= 1'b0;
      inv_f <= 1'b0;
    end else if (cmd.scan && rd_vld) begin
      if (q.valid && q.tag == tag_r && !hit_f) begin
        hit_f   <= 1'b1;
        hit_way <= rd_way;
        hit_old <= q.rec;
      end
      if (!q.valid && !inv_f) begin
        inv_f   <= 1'b1;
        inv_way <= rd_way;
      end
    end
    if (cmd.scan && rd_vld && (rd_way == '0 || q.rec < min_rec)) begin
      min_rec <= q.rec;
      min_way <= rd_way;
    end
  end

  logic [LINE_W-1:0] pick;
  assign pick = hit_f ? hit_way : (inv_f ? inv_way : min_way);

  // write port: clearing sweep or rank update
  logic              we;
  logic [LINE_W-1:0] wa;
  entry_t            wd;

  always_comb begin
    we = 1'b0;
    wa = base_r | rd_way;
    wd = q;
    if (cmd.clear) begin
      we = 1'b1;
      wa = clr_cnt;
      wd = '0;
    end else if (cmd.upd && rd_vld) begin
      we = 1'b1;
      if (rd_way == pick) begin
        wd.valid = 1'b1;
        wd.rec   = top;
        wd.tag   = hit_f ? q.tag : tag_r;
      end else if (q.rec != '0 && (!hit_f || q.rec > hit_old)) begin
        wd.rec = q.rec - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  // result register and running counts
  logic [COUNT_W-1:0] hits, accesses;
  logic               alloc_ok;

  assign alloc_ok = load_r || write_allocate;

  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      accesses  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        hits      <= hits + COUNT_W'(hit_f);
        accesses  <= accesses + 1'b1;
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.hit          <= hit_f;
      rsp.allocated    <= !hit_f && alloc_ok;
      rsp.hit_count    <= hits + COUNT_W'(hit_f);
      rsp.access_count <= accesses + 1'b1;
    end
  end

  always_comb begin
    sts.clear_done = (clr_cnt == {LINE_W{1'b1}});
    sts.walk_done  = (rd_cnt == ways_r) && !rd_vld;
    sts.hit        = hit_f;
    sts.alloc_ok   = alloc_ok;
    sts.out_free   = !rsp.valid || rsp.ready;
  end

endmodule

// ===== sv/set_assoc_lru_cache_tags.sv =====
`timescale 1ns / 1ps
// Tag store with true LRU ranks for a set-associative cache of TOTAL_LINES lines.
// After reset the block sweeps the tag memory once, one line a cycle, and takes
// no item until that is done. Each access then walks the ways of its set
// through the single memory read port: a scan pass and, when the access hits
// or allocates, an update pass that rewrites every way. A new item is taken
// only once the last one is done with its passes; a store miss that does not
// allocate skips the update pass. A result waits in an output register while
// the next item is taken.
module set_assoc_lru_cache_tags
  import salc_pkg::*;
#(
  parameter int TOTAL_LINES = TOTAL_LINES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  salc_req_if.sink              req,
  salc_rsp_if.source            rsp
);

  salc_cmd_t cmd;
  salc_sts_t sts;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salc_datapath #(
    .TOTAL_LINES (TOTAL_LINES),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .is_load   (req.is_load),
    .address   (req.address),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

// ===== sv/salc_checker.sv =====
`timescale 1ns / 1ps
module salc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic        out_allocated,
  input logic [31:0] out_access_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_access_count))
    else $error("access count changed while stalled");

  a_hit_no_alloc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_allocated))
    else $error("hit and allocate both set");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (req.valid),
  .in_ready         (req.ready),
  .out_valid        (rsp.valid),
  .out_ready        (rsp.ready),
  .out_hit          (rsp.hit),
  .out_allocated    (rsp.allocated),
  .out_access_count (rsp.access_count)
);
